[rtl/core/lpc_pkg.sv]
`default_nettype none

package lpc_pkg;

	// defaults for the top level parameters
	localparam int LPC_MAX_WIDTH   = 1024;
	localparam int LPC_MAX_HEIGHT  = 1024;
	localparam int LPC_LABEL_BITS  = 16;

	// depth of the queue between front and back
	localparam int LPC_QUEUE_DEPTH = 4;

	// configuration register widths and reset values
	localparam int          LPC_DIM_BITS     = 11;
	localparam int          LPC_TARGET_BITS  = 16;
	localparam int          LPC_COUNT_BITS   = 21;
	localparam logic [10:0] LPC_WIDTH_RESET  = 11'd1024;
	localparam logic [10:0] LPC_HEIGHT_RESET = 11'd1024;
	localparam logic [15:0] LPC_TARGET_RESET = 16'd1;

	// register indexes on the config port
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	// per pixel flags
	localparam logic [1:0] FLAG_ZERO   = 2'b01;
	localparam logic [1:0] FLAG_TARGET = 2'b10;

	// one window column is {bottom, middle, top}, two flag bits each
	localparam logic [5:0]  BG_COLUMN = 6'b01_01_01;
	localparam logic [17:0] BG_WINDOW = {BG_COLUMN, BG_COLUMN, BG_COLUMN};

	localparam logic [LPC_COUNT_BITS-1:0] COUNT_MAX = '1;

	// classified pixel, as it travels from front to back
	typedef struct packed {
		logic [1:0] flags;     // is target, is zero
		logic       top_en;    // row above the middle row exists
		logic       mid_en;    // middle row exists
		logic       test_en;   // window center is a real pixel
		logic       end_en;    // last column test at row end
		logic       win_clr;   // first column of a row
		logic       frame_end; // last pixel of the frame
	} pix_ctl_t;

	// back end stage control
	typedef struct packed {
		pix_ctl_t pix;
		logic     wr_en;      // pixel beat, row stores get updated
		logic     flush_last; // last column of the final row flush
	} bk_ctl_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_FLUSH,
		BK_WAIT,
		BK_EMIT
	} bk_state_t;

	// center is target and one of the eight neighbors is background
	function automatic logic edge_hit(input logic [17:0] win);
		logic any_zero;
		any_zero = win[0] | win[2] | win[4] | win[6] | win[10] | win[12] | win[14] | win[16];
		return win[9] & any_zero;
	endfunction

endpackage

`default_nettype wire

[rtl/core/label_perimeter_counter.sv]
// throughput: one pixel per cycle inside a frame while pixel_stall is low (queue not full)
// frame end: the final row flush reads the row store column by column; the queue takes
//   up to four pixels of the next frame, then pixel_stall holds until the count is loaded
// reset: arst_n clears positions, window, count and handshake state at once; row stores
//   are not cleared, registers return to width 1024, height 1024, target 1
`default_nettype none

module label_perimeter_counter import lpc_pkg::*; #(
	parameter int MAX_WIDTH  = LPC_MAX_WIDTH,
	parameter int MAX_HEIGHT = LPC_MAX_HEIGHT,
	parameter int LABEL_BITS = LPC_LABEL_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// config port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [3:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// pixel stream
	input  wire logic                      pixel_valid,
	output logic                           pixel_stall,
	input  wire logic [LABEL_BITS-1:0]     pixel_label,
	// perimeter result
	output logic                           count_valid,
	input  wire logic                      count_stall,
	output logic [LPC_COUNT_BITS-1:0]      perimeter_count
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int QW = $bits(pix_ctl_t) + AW;

	// configuration registers
	logic [LPC_DIM_BITS-1:0]    width_q;
	logic [LPC_DIM_BITS-1:0]    height_q;
	logic [LPC_TARGET_BITS-1:0] target_q;
	logic                       cfg_wr;

	// clamped geometry, zero reads as one, large values saturate
	logic [DW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	// front to queue
	logic          push;
	pix_ctl_t      push_ctl;
	logic [AW-1:0] push_col;
	logic          q_full;

	// queue to back
	logic          q_valid;
	logic [QW-1:0] q_data;
	logic          q_pop;
	pix_ctl_t      q_ctl;
	logic [AW-1:0] q_col;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= LPC_WIDTH_RESET;
			height_q <= LPC_HEIGHT_RESET;
			target_q <= LPC_TARGET_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[LPC_DIM_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[LPC_DIM_BITS-1:0];
				REG_TARGET: target_q <= pwdata[LPC_TARGET_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_TARGET: prdata = 32'(target_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = DW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// front: accepts pixel beats, turns labels into flags, tracks the raster position
	lpc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.LABEL_BITS (LABEL_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_label  (pixel_label),
		.target_label (target_q),
		.w_eff        (w_eff),
		.h_eff        (h_eff),
		.q_full       (q_full),
		.push         (push),
		.push_ctl     (push_ctl),
		.push_col     (push_col)
	);

	// short queue so the back can flush while the front keeps taking pixels
	lpc_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_ctl, push_col}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_data)
	);

	assign q_ctl = q_data[QW-1:AW];
	assign q_col = q_data[AW-1:0];

	// back: row stores, 3x3 window, edge tests, frame flush and result register
	lpc_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_ctl           (q_ctl),
		.q_col           (q_col),
		.q_pop           (q_pop),
		.w_eff           (w_eff),
		.count_valid     (count_valid),
		.count_stall     (count_stall),
		.perimeter_count (perimeter_count)
	);

endmodule

`default_nettype wire

[rtl/core/lpc_front.sv]
`default_nettype none

module lpc_front import lpc_pkg::*; #(
	parameter int MAX_WIDTH  = LPC_MAX_WIDTH,
	parameter int MAX_HEIGHT = LPC_MAX_HEIGHT,
	parameter int LABEL_BITS = LPC_LABEL_BITS,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int DW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pixel_valid,
	output logic                            pixel_stall,
	input  wire logic [LABEL_BITS-1:0]      pixel_label,
	input  wire logic [LPC_TARGET_BITS-1:0] target_label,
	input  wire logic [DW-1:0]              w_eff,
	input  wire logic [HW-1:0]              h_eff,
	input  wire logic                       q_full,
	output logic                            push,
	output pix_ctl_t                        push_ctl,
	output logic [AW-1:0]                   push_col
);

	localparam int LB = (LABEL_BITS < LPC_TARGET_BITS) ? LABEL_BITS : LPC_TARGET_BITS;

	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic          row_end;
	logic          frame_end;
	logic [1:0]    cur_flags;
	logic          accept;

	assign pixel_stall = q_full;
	assign accept      = pixel_valid && !q_full;

	assign row_end   = (DW'(col_q) + DW'(1)) >= w_eff;
	assign frame_end = row_end && ((row_q + HW'(1)) >= h_eff);

	assign cur_flags[0] = pixel_label[LB-1:0] == '0;
	assign cur_flags[1] = pixel_label[LB-1:0] == target_label[LB-1:0];

	always_comb begin
		push_ctl           = '0;
		push_ctl.flags     = cur_flags;
		push_ctl.top_en    = row_q > HW'(1);
		push_ctl.mid_en    = row_q != '0;
		push_ctl.test_en   = (row_q != '0) && (col_q != '0);
		push_ctl.end_en    = (row_q != '0) && row_end;
		push_ctl.win_clr   = col_q == '0;
		push_ctl.frame_end = frame_end;
	end

	assign push     = accept;
	assign push_col = col_q;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + HW'(1);
				end
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/lpc_queue.sv]
`default_nettype none

module lpc_queue import lpc_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic [WIDTH-1:0]      head_data
);

	localparam int PW = $clog2(LPC_QUEUE_DEPTH);
	localparam int CW = $clog2(LPC_QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [LPC_QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;
	logic             do_push;
	logic             do_pop;

	assign full       = fill_q == CW'(LPC_QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head_data  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == LPC_QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == LPC_QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/lpc_back.sv]
`default_nettype none

module lpc_back import lpc_pkg::*; #(
	parameter int MAX_WIDTH = LPC_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int DW = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	input  wire pix_ctl_t                  q_ctl,
	input  wire logic [AW-1:0]             q_col,
	output logic                           q_pop,
	input  wire logic [DW-1:0]             w_eff,
	output logic                           count_valid,
	input  wire logic                      count_stall,
	output logic [LPC_COUNT_BITS-1:0]      perimeter_count
);

	// row stores, one entry per column: {upper, middle}
	logic [3:0] row_mem [MAX_WIDTH];
	logic [3:0] rd_q;
	logic [3:0] wdata_q;
	logic       fwd_q;

	bk_state_t state_q, state_n;

	logic          issue;
	bk_ctl_t       issue_ctl;
	logic [AW-1:0] issue_col;
	logic          load_out;

	logic          s1_valid_q;
	bk_ctl_t       s1_ctl_q;
	logic [AW-1:0] s1_col_q;

	logic [AW-1:0] fk_q;
	logic          fk_last;
	logic          flush_top_q;

	logic [17:0]   win_q;
	logic [17:0]   win_base;
	logic [17:0]   win_n;
	logic [3:0]    rd;
	logic [1:0]    top;
	logic [1:0]    mid;
	logic          inc_a;
	logic          inc_b;
	logic [LPC_COUNT_BITS:0]   sum;
	logic [LPC_COUNT_BITS-1:0] total_q;
	logic [LPC_COUNT_BITS-1:0] total_n;

	logic                      count_valid_q;
	logic [LPC_COUNT_BITS-1:0] count_q;

	assign fk_last = (DW'(fk_q) + DW'(1)) == w_eff;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (s1_valid_q && s1_ctl_q.pix.frame_end) begin
					state_n = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (fk_last) begin
					state_n = BK_WAIT;
				end
			end
			BK_WAIT: begin
				if (s1_valid_q && s1_ctl_q.flush_last) begin
					state_n = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!count_valid_q || !count_stall) begin
					state_n = BK_RUN;
				end
			end
			default: state_n = BK_RUN;
		endcase
	end

	// issue control
	always_comb begin
		q_pop     = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		issue_ctl = '0;
		issue_col = fk_q;
		unique case (state_q)
			BK_RUN: begin
				if (q_valid && !(s1_valid_q && s1_ctl_q.pix.frame_end)) begin
					q_pop         = 1'b1;
					issue         = 1'b1;
					issue_ctl.pix = q_ctl;
					issue_ctl.wr_en = 1'b1;
					issue_col     = q_col;
				end
			end
			BK_FLUSH: begin
				// final row, background below it
				issue                   = 1'b1;
				issue_ctl.pix.flags     = FLAG_ZERO;
				issue_ctl.pix.top_en    = flush_top_q;
				issue_ctl.pix.mid_en    = 1'b1;
				issue_ctl.pix.test_en   = fk_q != '0;
				issue_ctl.pix.end_en    = fk_last;
				issue_ctl.pix.win_clr   = fk_q == '0;
				issue_ctl.flush_last    = fk_last;
			end
			BK_WAIT: begin
			end
			BK_EMIT: begin
				load_out = !count_valid_q || !count_stall;
			end
			default: begin
			end
		endcase
	end

	// row store access, read data registered
	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_ctl_q.wr_en) begin
			row_mem[s1_col_q] <= {rd[1:0], s1_ctl_q.pix.flags};
		end
		if (issue) begin
			rd_q <= row_mem[issue_col];
		end
		wdata_q  <= {rd[1:0], s1_ctl_q.pix.flags};
		s1_ctl_q <= issue_ctl;
		s1_col_q <= issue_col;
	end

	// window column and tests
	always_comb begin
		rd       = fwd_q ? wdata_q : rd_q;
		top      = s1_ctl_q.pix.top_en ? rd[3:2] : FLAG_ZERO;
		mid      = s1_ctl_q.pix.mid_en ? rd[1:0] : FLAG_ZERO;
		win_base = s1_ctl_q.pix.win_clr ? BG_WINDOW : win_q;
		win_n    = {s1_ctl_q.pix.flags, mid, top, win_base[17:6]};
		inc_a    = s1_ctl_q.pix.test_en && edge_hit(win_n);
		inc_b    = s1_ctl_q.pix.end_en && edge_hit({BG_COLUMN, win_n[17:6]});
		sum      = {1'b0, total_q} + (LPC_COUNT_BITS + 1)'(inc_a)
		         + (LPC_COUNT_BITS + 1)'(inc_b);
		total_n  = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[LPC_COUNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_RUN;
			s1_valid_q    <= 1'b0;
			fwd_q         <= 1'b0;
			fk_q          <= '0;
			flush_top_q   <= 1'b0;
			win_q         <= '0;
			total_q       <= '0;
			count_valid_q <= 1'b0;
		end else begin
			state_q    <= state_n;
			s1_valid_q <= issue;
			// same column written and read back to back
			fwd_q      <= issue && s1_valid_q && s1_ctl_q.wr_en && (issue_col == s1_col_q);
			if (state_q == BK_FLUSH) begin
				fk_q <= fk_q + AW'(1);
			end else begin
				fk_q <= '0;
			end
			if (s1_valid_q && s1_ctl_q.pix.frame_end) begin
				flush_top_q <= s1_ctl_q.pix.mid_en;
			end
			if (load_out) begin
				total_q <= '0;
				win_q   <= '0;
			end else if (s1_valid_q) begin
				total_q <= total_n;
				win_q   <= win_n;
			end
			if (load_out) begin
				count_valid_q <= 1'b1;
			end else if (!count_stall) begin
				count_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			count_q <= total_q;
		end
	end

	assign count_valid     = count_valid_q;
	assign perimeter_count = count_q;

endmodule

`default_nettype wire

[rtl/core/lpc_checker.sv]
`default_nettype none

module lpc_checker import lpc_pkg::*; #(
	parameter int LABEL_BITS = LPC_LABEL_BITS
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      psel,
	input wire logic                      penable,
	input wire logic                      pwrite,
	input wire logic [3:0]                paddr,
	input wire logic [31:0]               pwdata,
	input wire logic [31:0]               prdata,
	input wire logic                      pready,
	input wire logic                      pixel_valid,
	input wire logic                      pixel_stall,
	input wire logic [LABEL_BITS-1:0]     pixel_label,
	input wire logic                      count_valid,
	input wire logic                      count_stall,
	input wire logic [LPC_COUNT_BITS-1:0] perimeter_count
);

	// a stalled count beat stays
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && count_stall |=> count_valid)
		else $error("count beat dropped while stalled");

	// no count beat right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !count_valid)
		else $error("count beat right after reset");

	// a stalled count does not change
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && count_stall |=> $stable(perimeter_count))
		else $error("stalled count changed");

	// a stalled pixel beat is held by the sender
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_label))
		else $error("stalled pixel beat changed");

	// target label reads back what was just written
	a_target_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite && pready)
		&& psel && !pwrite && (paddr == $past(paddr)) && (paddr[3:2] == REG_TARGET)
		|-> prdata[LPC_TARGET_BITS-1:0] == $past(pwdata[LPC_TARGET_BITS-1:0]))
		else $error("target label read back mismatch");

endmodule

bind label_perimeter_counter lpc_checker #(.LABEL_BITS(LABEL_BITS)) u_lpc_checker (.*);

`default_nettype wire

[dv/label_perimeter_counter_tb.sv]
module label_perimeter_counter_tb;
	import lpc_pkg::*;

	localparam int          MAX_W       = LPC_MAX_WIDTH;
	localparam int          MAX_H       = LPC_MAX_HEIGHT;
	localparam int unsigned CYCLE_LIMIT = 600000;

	// receiver stall patterns, each kept for a random stretch of cycles
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_PERIODIC,
		STALL_COIN,
		STALL_HEAVY
	} stall_mode_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// config port
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// pixel stream in, perimeter beats out
	logic                      pixel_valid = 1'b0;
	logic                      pixel_stall;
	logic [LPC_LABEL_BITS-1:0] pixel_label = '0;
	logic                      count_valid;
	logic                      count_stall = 1'b0;
	logic [LPC_COUNT_BITS-1:0] perimeter_count;

	// expected perimeter counts, one per finished frame, oldest first
	logic [LPC_COUNT_BITS-1:0] perimeter_expect [$];
	logic [LPC_COUNT_BITS-1:0] count_want;

	// shadow of the boundary counter: flag rows, 3x3 flag window, raster position
	logic [1:0]                upper_flags [MAX_W];
	logic [1:0]                middle_flags [MAX_W];
	logic [17:0]               flag_win = '0;
	int unsigned               col_pos = 0;
	int unsigned               row_pos = 0;
	logic [LPC_COUNT_BITS-1:0] perim_total = '0;
	logic [LPC_DIM_BITS-1:0]   cfg_width = LPC_WIDTH_RESET;
	logic [LPC_DIM_BITS-1:0]   cfg_height = LPC_HEIGHT_RESET;
	logic [LPC_TARGET_BITS-1:0] cfg_target = LPC_TARGET_RESET;

	// traffic shaping
	bit          gaps_on = 1'b1;
	int unsigned burst_left = 0;
	int unsigned hold_left = 0;
	int unsigned stall_seg_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	label_perimeter_counter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.pixel_label     (pixel_label),
		.count_valid     (count_valid),
		.count_stall     (count_stall),
		.perimeter_count (perimeter_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a beat never shows up
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
	endtask

	// ------------------------------------------------------------------
	// boundary pixel predictor
	// ------------------------------------------------------------------

	// zero reads as one, values over the maximum saturate
	function automatic int unsigned clamp_dim(input logic [LPC_DIM_BITS-1:0] v,
			input int unsigned lim);
		if (v == 0)
			return 1;
		return (32'(v) > lim) ? lim : 32'(v);
	endfunction

	// oldest column drops out at the bottom, new column {bottom, middle, top} goes on top
	function automatic logic [17:0] slide(input logic [17:0] win, input logic [5:0] column);
		return {column, win[17:6]};
	endfunction

	// center is target and any of the eight neighbors is background
	function automatic bit boundary_hit(input logic [17:0] win);
		if (!win[9])
			return 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && win[2 * i])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_hit(input bit hit);
		if (hit && perim_total != COUNT_MAX)
			perim_total++;
	endfunction

	// advances the shadow by one pixel beat; returns 1 with the count at frame end
	function automatic bit predict_pixel(input logic [LPC_TARGET_BITS-1:0] lbl,
			output logic [LPC_COUNT_BITS-1:0] cnt);
		int unsigned w, h, c, r, k;
		logic [1:0]  cur, top, mid, above;
		logic [5:0]  nxt;
		logic [17:0] fw;
		cnt = '0;
		w = clamp_dim(cfg_width, MAX_W);
		h = clamp_dim(cfg_height, MAX_H);
		c = col_pos % MAX_W;
		r = row_pos;
		cur = ((lbl == 0) ? FLAG_ZERO : 2'b00) | ((lbl == cfg_target) ? FLAG_TARGET : 2'b00);
		top = (r >= 2) ? upper_flags[c] : FLAG_ZERO;
		mid = (r >= 1) ? middle_flags[c] : FLAG_ZERO;
		upper_flags[c] = middle_flags[c];
		middle_flags[c] = cur;
		if (c == 0)
			flag_win = BG_WINDOW;
		flag_win = slide(flag_win, {cur, mid, top});
		// the new column completes the test of the pixel up and to the left
		if (r >= 1 && c >= 1)
			add_hit(boundary_hit(flag_win));
		if (c + 1 < w) begin
			col_pos = c + 1;
			return 1'b0;
		end
		// row end, last column of the row above sees background on its right
		if (r >= 1)
			add_hit(boundary_hit(slide(flag_win, BG_COLUMN)));
		col_pos = 0;
		if (r + 1 < h) begin
			row_pos = r + 1;
			return 1'b0;
		end
		// frame end, final row gets tested against a background row below
		above = (r >= 1) ? upper_flags[0] : FLAG_ZERO;
		fw = slide(BG_WINDOW, {FLAG_ZERO, middle_flags[0], above});
		for (k = 0; k < w; k++) begin
			if (k + 1 < w) begin
				above = (r >= 1) ? upper_flags[k + 1] : FLAG_ZERO;
				nxt = {FLAG_ZERO, middle_flags[k + 1], above};
			end else begin
				nxt = BG_COLUMN;
			end
			fw = slide(fw, nxt);
			add_hit(boundary_hit(fw));
		end
		cnt = perim_total;
		perim_total = '0;
		row_pos = 0;
		flag_win = '0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// pixel sender, bursts with random gaps when gaps_on is set
	// ------------------------------------------------------------------

	task automatic send_pixel(input logic [LPC_TARGET_BITS-1:0] lbl);
		logic [LPC_COUNT_BITS-1:0] frame_count;
		pixel_valid <= 1'b1;
		pixel_label <= lbl;
		do
			@(posedge clk);
		while (pixel_stall);
		// beat taken at this edge
		if (predict_pixel(lbl, frame_count))
			perimeter_expect.push_back(frame_count);
		if (gaps_on) begin
			if (burst_left == 0) begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(0, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	// sender goes quiet until every pending count has come back
	task automatic wait_results_drained();
		pixel_valid <= 1'b0;
		do
			@(posedge clk);
		while (perimeter_expect.size() != 0);
	endtask

	// label mix: background, target, a few small other labels, full range noise
	function automatic logic [LPC_TARGET_BITS-1:0] pick_label(input int unsigned pct_bg,
			input int unsigned pct_tgt);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < pct_bg)
			return '0;
		if (roll < pct_bg + pct_tgt)
			return cfg_target;
		if (roll[0])
			return LPC_TARGET_BITS'($urandom_range(1, 5));
		return LPC_TARGET_BITS'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// config port
	// ------------------------------------------------------------------

	// one setup and one access phase, then psel goes low
	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data,
			output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rd = prdata;
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// waits for an idle block, writes, reads back and updates the shadow
	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd, kept;
		wait_results_drained();
		// pixels of an unfinished frame may still be in flight
		repeat (clamp_dim(cfg_width, MAX_W) + 16) @(posedge clk);
		kept = val;
		case (idx)
			REG_WIDTH, REG_HEIGHT: begin
				kept = val & ((32'd1 << LPC_DIM_BITS) - 1);
			end
			default: begin
				kept = val & ((32'd1 << LPC_TARGET_BITS) - 1);
			end
		endcase
		apb_access(1'b1, idx, val, rd);
		apb_access(1'b0, idx, '0, rd);
		if (rd !== kept)
			report_mismatch("register readback", rd, kept);
		case (idx)
			REG_WIDTH: begin
				cfg_width = kept[LPC_DIM_BITS-1:0];
			end
			REG_HEIGHT: begin
				cfg_height = kept[LPC_DIM_BITS-1:0];
			end
			default: begin
				cfg_target = kept[LPC_TARGET_BITS-1:0];
			end
		endcase
	endtask

	task automatic send_frames(input int unsigned frames, input int unsigned pct_bg,
			input int unsigned pct_tgt);
		repeat (frames * clamp_dim(cfg_width, MAX_W) * clamp_dim(cfg_height, MAX_H))
			send_pixel(pick_label(pct_bg, pct_tgt));
	endtask

	// ------------------------------------------------------------------
	// result checker and receiver stall
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && count_valid === 1'b1 && !count_stall) begin
			if (perimeter_expect.size() == 0) begin
				report_mismatch("perimeter_count beat with no frame pending",
					32'(perimeter_count), 32'd0);
			end else begin
				count_want = perimeter_expect.pop_front();
				if (perimeter_count !== count_want)
					report_mismatch("perimeter_count", 32'(perimeter_count),
						32'(count_want));
			end
		end
	end

	// long hold-off when asked, otherwise a pattern that changes every stretch
	always @(posedge clk) begin
		if (hold_left != 0) begin
			count_stall <= 1'b1;
			hold_left--;
		end else begin
			if (stall_seg_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_seg_left = $urandom_range(16, 160);
			end
			stall_seg_left--;
			case (stall_mode)
				STALL_NONE: begin
					count_stall <= 1'b0;
				end
				STALL_PERIODIC: begin
					count_stall <= (stall_seg_left % 3) == 0;
				end
				STALL_COIN: begin
					count_stall <= 1'($urandom_range(0, 1));
				end
				default: begin
					count_stall <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_register_defaults();
		logic [31:0] rd;
		apb_access(1'b0, REG_WIDTH, '0, rd);
		if (rd !== 32'(LPC_WIDTH_RESET))
			report_mismatch("image_width after reset", rd, 32'(LPC_WIDTH_RESET));
		apb_access(1'b0, REG_HEIGHT, '0, rd);
		if (rd !== 32'(LPC_HEIGHT_RESET))
			report_mismatch("image_height after reset", rd, 32'(LPC_HEIGHT_RESET));
		apb_access(1'b0, REG_TARGET, '0, rd);
		if (rd !== 32'(LPC_TARGET_RESET))
			report_mismatch("target_label after reset", rd, 32'(LPC_TARGET_RESET));
	endtask

	// one pixel frames: top label as target, background, some other label
	task automatic test_single_pixels();
		set_reg(REG_WIDTH, 1);
		set_reg(REG_HEIGHT, 1);
		set_reg(REG_TARGET, 32'hFFFF);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h0001);
	endtask

	// zero width and height behave as one
	task automatic test_dimension_clamp();
		set_reg(REG_WIDTH, 0);
		set_reg(REG_HEIGHT, 0);
		set_reg(REG_TARGET, 5);
		send_pixel(16'd5);
		send_pixel(16'd5);
	endtask

	// target zero: background pixels count as target too
	task automatic test_target_zero();
		set_reg(REG_WIDTH, 2);
		set_reg(REG_HEIGHT, 2);
		set_reg(REG_TARGET, 0);
		send_pixel(16'd0);
		send_pixel(16'd4);
		send_pixel(16'd0);
		send_pixel(16'd0);
	endtask

	// small object with a background pixel, two foreign labels and an interior pixel
	task automatic test_small_object();
		logic [15:0] pattern [12];
		pattern = '{16'd7, 16'd7, 16'd7, 16'd0,
			16'd7, 16'd7, 16'd3, 16'd7,
			16'hFFFF, 16'd7, 16'd7, 16'd7};
		set_reg(REG_WIDTH, 4);
		set_reg(REG_HEIGHT, 3);
		set_reg(REG_TARGET, 7);
		foreach (pattern[i])
			send_pixel(pattern[i]);
	endtask

	// geometry lowered in mid-frame below the current position
	task automatic test_geometry_change();
		set_reg(REG_WIDTH, 2);
		set_reg(REG_HEIGHT, 4);
		set_reg(REG_TARGET, 1);
		send_pixel(16'd1);
		send_pixel(16'd1);
		send_pixel(16'd0);
		send_pixel(16'd1);
		// row 2 is past the new height, frame closes at the end of this row
		set_reg(REG_HEIGHT, 1);
		send_pixel(16'd1);
		send_pixel(16'd1);
		set_reg(REG_WIDTH, 3);
		set_reg(REG_HEIGHT, 2);
		send_pixel(16'd1);
		send_pixel(16'd1);
		// column 2 is past the new width, row closes at the next pixel
		set_reg(REG_WIDTH, 1);
		send_pixel(16'd1);
		send_pixel(16'd1);
	endtask

	// counts held back while frames keep coming, then a full pause
	task automatic test_backpressure();
		set_reg(REG_WIDTH, 3);
		set_reg(REG_HEIGHT, 2);
		set_reg(REG_TARGET, 2);
		gaps_on = 1'b0;
		hold_left = 400;
		send_frames(4, 30, 50);
		wait_results_drained();
		gaps_on = 1'b1;
	endtask

	// saturated width and height, each frame closed early by lowering the geometry
	task automatic test_max_geometry();
		set_reg(REG_WIDTH, 32'h7FF);
		set_reg(REG_HEIGHT, 32'h7FF);
		set_reg(REG_TARGET, 9);
		repeat (48) send_pixel(pick_label(25, 55));
		// still in row 0, row and frame close at the next pixel
		set_reg(REG_HEIGHT, 1);
		set_reg(REG_WIDTH, 24);
		send_pixel(pick_label(25, 55));
		// one column, many rows, frame closes at the next pixel
		set_reg(REG_HEIGHT, 32'h7FF);
		set_reg(REG_WIDTH, 1);
		repeat (20) send_pixel(pick_label(25, 55));
		set_reg(REG_HEIGHT, 4);
		send_pixel(pick_label(25, 55));
	endtask

	task automatic test_random_frames();
		int unsigned frames, px, pct_bg, pct_tgt, roll;
		frames = 0;
		px = 0;
		while (px < 400 || frames < 12) begin
			if (frames == 0 || $urandom_range(0, 2) == 0) begin
				set_reg(REG_WIDTH, ($urandom_range(0, 9) == 0) ?
					$urandom_range(9, 24) : $urandom_range(0, 8));
				set_reg(REG_HEIGHT, ($urandom_range(0, 9) == 0) ?
					$urandom_range(7, 12) : $urandom_range(0, 6));
			end
			roll = $urandom_range(0, 11);
			if (roll == 0)
				set_reg(REG_TARGET, 0);
			else if (roll == 1)
				set_reg(REG_TARGET, $urandom);
			else if (roll < 5)
				set_reg(REG_TARGET, $urandom_range(1, 5));
			else if (roll == 5)
				wait_results_drained();
			pct_bg = $urandom_range(5, 60);
			pct_tgt = $urandom_range(10, 90 - pct_bg);
			px += clamp_dim(cfg_width, MAX_W) * clamp_dim(cfg_height, MAX_H);
			send_frames(1, pct_bg, pct_tgt);
			frames++;
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_W; i++) begin
			upper_flags[i] = '0;
			middle_flags[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_single_pixels();
		test_dimension_clamp();
		test_target_zero();
		test_small_object();
		test_geometry_change();
		test_backpressure();
		test_max_geometry();
		test_random_frames();
		// all counts back, then a quiet tail to catch stray beats
		wait_results_drained();
		repeat (clamp_dim(cfg_width, MAX_W) + 32) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
